/* design/i2c_write_target_receiver_unit_defines.svh */
// Assertion macros for the I2C write target receiver.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef I2C_WRITE_TARGET_RECEIVER_UNIT_DEFINES_SVH
`define I2C_WRITE_TARGET_RECEIVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define WTR_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("i2c_wtr: assertion failed");

// Next-cycle implication, disabled during reset
`define WTR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c_wtr: next-cycle assertion failed");

`else

`define WTR_ASSERT(name, clk, rst_n, prop)
`define WTR_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

/* design/i2c_wtr_pkg.sv */
// Shared types and constants of the I2C write target receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2c_wtr_pkg;

    // Widths
    localparam int COUNT_WIDTH   = 16;
    localparam int ADDR_W        = 7;
    localparam int BYTE_W        = 8;
    localparam int BITCNT_W      = 4;
    localparam int FLAGS_W       = 4;
    localparam int CFG_DATA_W    = 7;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 32;

    // Bus phase codes
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_RECEIVE  = 2'd1;
    localparam logic [1:0] PH_ACK_PREP = 2'd2;
    localparam logic [1:0] PH_ACK_HIGH = 2'd3;

    // Configuration register indexes
    localparam logic CFG_ENABLE  = 1'b0;
    localparam logic CFG_ADDRESS = 1'b1;

    // Constants
    localparam logic [FLAGS_W-1:0]  FLAGS_BASE    = 4'h9;
    localparam logic [FLAGS_W-1:0]  FLAG_CLOCK    = 4'h2;
    localparam logic [FLAGS_W-1:0]  FLAG_DATA     = 4'h4;
    localparam logic [BYTE_W-1:0]   BYTE_SAT      = 8'hff;
    localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = 4'd8;

    // One result item
    typedef struct packed {
        logic                   status_valid;
        logic [FLAGS_W-1:0]     status_flags;
        logic [BYTE_W-1:0]      byte_count;
        logic [COUNT_WIDTH-1:0] transaction_count;
        logic                   addressed;
        logic                   sda_pull_low;
    } result_t;

endpackage

`default_nettype wire

/* design/i2c_wtr_core.sv */
// Bus state tracker: start/stop detection, bit shifting, address match, ack.
// Depends on i2c_wtr_pkg and the assertion macro header.
`default_nettype none
`include "i2c_write_target_receiver_unit_defines.svh"

module i2c_wtr_core (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic                                   cfg_index,
    input  wire logic [i2c_wtr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                   accept,
    input  wire logic                                   sda,
    input  wire logic                                   scl,
    output i2c_wtr_pkg::result_t                        result
);
    import i2c_wtr_pkg::*;

    logic                   enable_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [1:0]             phase_reg,    phase_next;
    logic [BITCNT_W-1:0]    bitcnt_reg,   bitcnt_next;
    logic [BYTE_W-1:0]      shift_reg,    shift_next;
    logic                   selected_reg, selected_next;
    logic                   ack_reg,      ack_next;
    logic                   prev_sda_reg;
    logic                   prev_scl_reg;
    logic                   drive_reg,    drive_next;
    logic [COUNT_WIDTH-1:0] txn_reg,      txn_next;
    logic [BYTE_W-1:0]      bytes_reg,    bytes_next;

    logic start_cond;
    logic stop_cond;
    logic scl_rise;
    logic scl_fall;
    logic addr_match;
    logic cfg_enable_wr;

    assign start_cond = prev_sda_reg & ~sda & scl;
    assign stop_cond  = ~prev_sda_reg & sda & scl;
    assign scl_rise   = ~prev_scl_reg & scl;
    assign scl_fall   = prev_scl_reg & ~scl;

    // An enable write owns phase and drive in its cycle
    assign cfg_enable_wr = cfg_we && (cfg_index == CFG_ENABLE);

    // Address byte matches own address with the write bit clear
    assign addr_match = ({shift_reg[BYTE_W-2:0], sda} == {addr_reg, 1'b0});

    // Next state for one sample, in the order start, stop, rise, fall
    always_comb
    begin
        phase_next    = phase_reg;
        bitcnt_next   = bitcnt_reg;
        shift_next    = shift_reg;
        selected_next = selected_reg;
        ack_next      = ack_reg;
        drive_next    = drive_reg;
        txn_next      = txn_reg;
        bytes_next    = bytes_reg;

        if (start_cond)
        begin
            phase_next    = PH_RECEIVE;
            bitcnt_next   = '0;
            shift_next    = '0;
            selected_next = 1'b0;
            ack_next      = 1'b0;
            drive_next    = 1'b0;
        end
        if (stop_cond)
        begin
            phase_next    = PH_IDLE;
            selected_next = 1'b0;
            drive_next    = 1'b0;
        end

        // Shift in one bit; judge the byte once eight have arrived
        if (scl_rise && phase_next == PH_RECEIVE)
        begin
            shift_next  = {shift_next[BYTE_W-2:0], sda};
            bitcnt_next = bitcnt_next + 1'b1;
            if (bitcnt_next == BITS_PER_BYTE)
            begin
                if (!selected_next)
                begin
                    // start clears the shifter, so the fresh byte is all but
                    // the new bit; start and completion cannot coincide here
                    selected_next = addr_match;
                    ack_next      = addr_match;
                    if (addr_match)
                        txn_next = txn_reg + 1'b1;
                end
                else
                begin
                    ack_next = 1'b1;
                    if (bytes_reg != BYTE_SAT)
                        bytes_next = bytes_reg + 1'b1;
                end
                phase_next = PH_ACK_PREP;
            end
        end

        // Drive the acknowledge on a falling SCL in ack prep, release it on a falling SCL in ack high
        if (scl_fall && phase_next == PH_ACK_PREP)
        begin
            drive_next = ack_next;
            phase_next = PH_ACK_HIGH;
        end
        else if (scl_fall && phase_next == PH_ACK_HIGH)
        begin
            drive_next  = 1'b0;
            phase_next  = PH_RECEIVE;
            bitcnt_next = '0;
            shift_next  = '0;
        end
    end

    // State registers; configuration writes take effect at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            addr_reg     <= '0;
            phase_reg    <= PH_IDLE;
            bitcnt_reg   <= '0;
            shift_reg    <= '0;
            selected_reg <= 1'b0;
            ack_reg      <= 1'b0;
            prev_sda_reg <= 1'b1;
            prev_scl_reg <= 1'b1;
            drive_reg    <= 1'b0;
            txn_reg      <= '0;
            bytes_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                prev_sda_reg <= sda;
                prev_scl_reg <= scl;
                if (enable_reg)
                begin
                    bitcnt_reg   <= bitcnt_next;
                    shift_reg    <= shift_next;
                    selected_reg <= selected_next;
                    ack_reg      <= ack_next;
                    txn_reg      <= txn_next;
                    bytes_reg    <= bytes_next;
                    if (!cfg_enable_wr)
                    begin
                        phase_reg <= phase_next;
                        drive_reg <= drive_next;
                    end
                end
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ENABLE:
                    begin
                        enable_reg <= cfg_data[0];
                        drive_reg  <= 1'b0;
                        if (!cfg_data[0])
                            phase_reg <= PH_IDLE;
                    end
                    CFG_ADDRESS:
                    begin
                        addr_reg <= cfg_data[ADDR_W-1:0];
                    end
                    default:
                    begin
                        addr_reg <= addr_reg;
                    end
                endcase
            end
        end
    end

    // Result for this sample; everything reads zero while disabled
    always_comb
    begin
        if (enable_reg)
        begin
            result.sda_pull_low      = drive_next;
            result.addressed         = selected_next;
            result.transaction_count = txn_next;
            result.byte_count        = bytes_next;
            result.status_flags      = FLAGS_BASE | (scl ? FLAG_CLOCK : '0)
                                                  | (sda ? FLAG_DATA : '0);
            result.status_valid      = 1'b1;
        end
        else
        begin
            result = '0;
        end
    end

    `WTR_ASSERT(a_drive_needs_enable, clk, rst_n, !drive_reg || enable_reg)
    `WTR_ASSERT(a_drive_only_in_ack, clk, rst_n, !drive_reg || phase_reg == PH_ACK_HIGH)
    `WTR_ASSERT(a_ack_prep_full_byte, clk, rst_n,
                phase_reg != PH_ACK_PREP || bitcnt_reg == BITS_PER_BYTE)
    `WTR_ASSERT_NEXT(a_disabled_holds_count, clk, rst_n,
                     !enable_reg && !cfg_we, $stable(txn_reg) && $stable(bytes_reg))

endmodule

`default_nettype wire

/* design/i2c_wtr_out.sv */
// Result register between the state tracker and the output stream.
// Depends on i2c_wtr_pkg for the result item type.
`default_nettype none

module i2c_wtr_out (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire i2c_wtr_pkg::result_t   result,
    input  wire logic                   take,
    output logic                        valid,
    output logic                        room,
    output i2c_wtr_pkg::result_t        data
);
    import i2c_wtr_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // Room for a new item when empty or when the held one leaves now
    assign room  = ~valid_reg | take;
    assign valid = valid_reg;
    assign data  = data_reg;

    // Hold the valid flag until the item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (take)
            valid_reg <= 1'b0;
    end

    // Load the payload with each accepted item
    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

endmodule

`default_nettype wire

/* design/i2c_write_target_receiver_unit.sv */
// I2C write target receiver: one bus sample in, one status item out.
// The result of a sample is registered and on the output in the cycle after it is accepted.
// Throughput: one item per cycle unless output stalls; single state pass, one register.
// Reset (rst_n, async, active low): disabled, address 0, phase idle, counters zero,
// previous line levels high, output empty.
`default_nettype none

module i2c_write_target_receiver_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration write port
    input  wire logic                                  cfg_we,
    input  wire logic                                  cfg_index,
    input  wire logic [i2c_wtr_pkg::CFG_DATA_W-1:0]    cfg_data,
    // sample stream
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [0] sda_sample, [1] scl_sample, [7:2] zero
    input  wire logic [i2c_wtr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // result stream
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [0] sda_pull_low, [1] addressed, [17:2] transaction_count,
    // [25:18] byte_count, [29:26] status_flags, [30] status_valid, [31] zero
    output logic [i2c_wtr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
    import i2c_wtr_pkg::*;

    logic    accept;
    logic    room;
    result_t core_result;
    result_t out_data;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid & room;

    // Track the bus and build the result for each sample
    i2c_wtr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .sda       (s_axis_tdata[0]),
        .scl       (s_axis_tdata[1]),
        .result    (core_result)
    );

    // Hold the result until the downstream side takes it
    i2c_wtr_out u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .result (core_result),
        .take   (m_axis_tready),
        .valid  (m_axis_tvalid),
        .room   (room),
        .data   (out_data)
    );

    // Pack the result item, first declared field highest, with a zero top bit
    assign m_axis_tdata = {1'b0, out_data};

endmodule

`default_nettype wire

/* tb/sv/i2c_wtr_bus_checker.sv */
// Status checker for the I2C write target receiver: mirrors the target on every
// accepted bus sample and compares each status item leaving the block.
// Depends on i2c_wtr_pkg for the result layout, phase codes and register indexes.
module i2c_wtr_bus_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [i2c_wtr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                                s_axis_tvalid,
    input  wire logic                                s_axis_tready,
    input  wire logic [i2c_wtr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [i2c_wtr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output int unsigned                              fail_count,
    output int unsigned                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import i2c_wtr_pkg::*;

    localparam int RES_W = $bits(result_t);

    // Mirror of the target state and its registers
    logic                   bus_enabled;
    logic [ADDR_W-1:0]      own_address;
    logic [1:0]             bus_phase;
    logic [BITCNT_W-1:0]    bit_count;
    logic [BYTE_W-1:0]      rx_byte;
    logic                   selected;
    logic                   ack_owed;
    logic                   last_sda;
    logic                   last_scl;
    logic                   pull_low;
    logic [COUNT_WIDTH-1:0] write_count;
    logic [BYTE_W-1:0]      data_bytes;

    result_t     expected_status[$];
    result_t     want;
    result_t     got;
    result_t     fresh;
    int unsigned mismatches;

    // Count a mismatch; show only the first few
    task automatic note_mismatch(input string what, input longint unsigned want_v,
                                 input longint unsigned got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, what,
                     want_v, got_v);
    endtask

    // Advance the mirrored target by one bus sample and form its status item
    task automatic track_bus_sample(input logic sda, input logic scl, output result_t res);
        res = '0;
        if (!bus_enabled)
        begin
            last_sda = sda;
            last_scl = scl;
            return;
        end
        // start: SDA falls while SCL is high
        if (last_sda && !sda && scl)
        begin
            bus_phase = PH_RECEIVE;
            bit_count = '0;
            rx_byte   = '0;
            selected  = 1'b0;
            ack_owed  = 1'b0;
            pull_low  = 1'b0;
        end
        // stop: SDA rises while SCL is high
        if (!last_sda && sda && scl)
        begin
            bus_phase = PH_IDLE;
            selected  = 1'b0;
            pull_low  = 1'b0;
        end
        // shift in on rising SCL, decide on the eighth bit
        if (!last_scl && scl && bus_phase == PH_RECEIVE)
        begin
            rx_byte   = {rx_byte[BYTE_W-2:0], sda};
            bit_count = bit_count + 1'b1;
            if (bit_count == BITS_PER_BYTE)
            begin
                if (!selected)
                begin
                    selected = (rx_byte[BYTE_W-1:1] == own_address) && !rx_byte[0];
                    ack_owed = selected;
                    if (selected)
                        write_count = write_count + 1'b1;
                end
                else
                begin
                    ack_owed = 1'b1;
                    if (data_bytes != BYTE_SAT)
                        data_bytes = data_bytes + 1'b1;
                end
                bus_phase = PH_ACK_PREP;
            end
        end
        // on falling SCL drive the acknowledge in ack prep, release it in ack high
        if (last_scl && !scl)
        begin
            if (bus_phase == PH_ACK_PREP)
            begin
                pull_low  = ack_owed;
                bus_phase = PH_ACK_HIGH;
            end
            else if (bus_phase == PH_ACK_HIGH)
            begin
                pull_low  = 1'b0;
                bus_phase = PH_RECEIVE;
                bit_count = '0;
                rx_byte   = '0;
            end
        end
        last_sda = sda;
        last_scl = scl;

        res.sda_pull_low      = pull_low;
        res.addressed         = selected;
        res.transaction_count = write_count;
        res.byte_count        = data_bytes;
        res.status_flags      = FLAGS_BASE | (scl ? FLAG_CLOCK : '0) | (sda ? FLAG_DATA : '0);
        res.status_valid      = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_enabled = 1'b0;
            own_address = '0;
            bus_phase   = PH_IDLE;
            bit_count   = '0;
            rx_byte     = '0;
            selected    = 1'b0;
            ack_owed    = 1'b0;
            last_sda    = 1'b1;
            last_scl    = 1'b1;
            pull_low    = 1'b0;
            write_count = '0;
            data_bytes  = '0;
            mismatches  = 0;
            expected_status.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // compare the outgoing item with the oldest expectation
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[RES_W-1:0]);
                if (expected_status.size() == 0)
                    note_mismatch("unexpected item", 0, m_axis_tdata);
                else
                begin
                    want = expected_status.pop_front();
                    if (got.sda_pull_low !== want.sda_pull_low)
                        note_mismatch("sda_pull_low", want.sda_pull_low, got.sda_pull_low);
                    if (got.addressed !== want.addressed)
                        note_mismatch("addressed", want.addressed, got.addressed);
                    if (got.transaction_count !== want.transaction_count)
                        note_mismatch("transaction_count", want.transaction_count,
                                      got.transaction_count);
                    if (got.byte_count !== want.byte_count)
                        note_mismatch("byte_count", want.byte_count, got.byte_count);
                    if (got.status_flags !== want.status_flags)
                        note_mismatch("status_flags", want.status_flags, got.status_flags);
                    if (got.status_valid !== want.status_valid)
                        note_mismatch("status_valid", want.status_valid, got.status_valid);
                    if (m_axis_tdata[OUT_TDATA_W-1:RES_W] !== '0)
                        note_mismatch("padding", 0, m_axis_tdata[OUT_TDATA_W-1:RES_W]);
                end
            end

            // register writes; any enable write releases SDA
            if (cfg_we)
            begin
                if (cfg_index == CFG_ENABLE)
                begin
                    bus_enabled = cfg_data[0];
                    pull_low    = 1'b0;
                    if (!cfg_data[0])
                        bus_phase = PH_IDLE;
                end
                else if (cfg_index == CFG_ADDRESS)
                    own_address = cfg_data[ADDR_W-1:0];
            end

            // predict the item for an accepted sample
            if (s_axis_tvalid && s_axis_tready)
            begin
                track_bus_sample(s_axis_tdata[0], s_axis_tdata[1], fresh);
                expected_status.push_back(fresh);
            end

            fail_count <= mismatches;
            pending    <= expected_status.size();
        end
    end

endmodule

/* tb/sv/tb_i2c_write_target_receiver_unit.sv */
// Testbench top for the I2C write target receiver: drives oversampled bus traffic
// and register writes, and gives the verdict from the status checker.
// Depends on i2c_wtr_pkg, i2c_write_target_receiver_unit and i2c_wtr_bus_checker.
module tb_i2c_write_target_receiver_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import i2c_wtr_pkg::*;

    localparam int RANDOM_SAMPLES = 540;
    localparam int LONG_BYTES     = 2;
    localparam int QUIET_LIMIT    = 3000;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic                   cfg_index     = CFG_ENABLE;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int unsigned fail_count;
    int unsigned pending;

    int unsigned     idle_in      = 38;
    int unsigned     idle_out     = 78;
    int unsigned     hold_max     = 2;
    int unsigned     samples_sent = 0;
    int unsigned     quiet_cycles = 0;
    logic [ADDR_W-1:0] own_addr   = '0;

    i2c_write_target_receiver_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    i2c_wtr_bus_checker bus_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stall the result side at random
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= idle_out);

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one bus sample, with random gaps before it
    task automatic push_sample(input logic sda, input logic scl);
        while ($urandom_range(99) < idle_in)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-2){1'b0}}, scl, sda};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        samples_sent++;
    endtask

    // Hold a line level for one or more samples (oversampling)
    task automatic hold_level(input logic sda, input logic scl);
        int unsigned reps;
        reps = 1;
        if (hold_max > 1 && $urandom_range(99) < 30)
            reps = $urandom_range(hold_max, 2);
        repeat (reps)
            push_sample(sda, scl);
    endtask

    // Write a register once nothing is in flight
    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ADDRESS)
            own_addr = value[ADDR_W-1:0];
    endtask

    // Rewrite enable: mostly a plain re-enable, sometimes a short disabled stretch
    task automatic toggle_enable();
        if ($urandom_range(99) < 30)
        begin
            write_reg(CFG_ENABLE, {6'($urandom_range(63)), 1'b0});
            repeat ($urandom_range(4, 1))
                push_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
        end
        write_reg(CFG_ENABLE, {6'($urandom_range(63)), 1'b1});
    endtask

    task automatic put_bit(input logic b);
        hold_level(b, 1'b0);
        hold_level(b, 1'b1);
    endtask

    // Eight bits MSB first, then the acknowledge slot
    task automatic put_byte(input logic [BYTE_W-1:0] value);
        logic ack_level;
        ack_level = 1'($urandom_range(1));
        for (int i = BYTE_W - 1; i >= 0; i--)
            put_bit(value[i]);
        push_sample(ack_level, 1'b0);
        // the target is driving the acknowledge here
        if ($urandom_range(99) < 8)
            toggle_enable();
        hold_level(ack_level, 1'b1);
    endtask

    task automatic bus_start();
        hold_level(1'b1, 1'b0);
        hold_level(1'b1, 1'b1);
        hold_level(1'b0, 1'b1);
    endtask

    task automatic bus_stop();
        hold_level(1'b0, 1'b0);
        hold_level(1'b0, 1'b1);
        hold_level(1'b1, 1'b1);
    endtask

    // Start, address byte, a few data bytes, then a stop or an abandoned byte
    task automatic run_write(input int unsigned n_data);
        int unsigned       pick;
        logic [BYTE_W-1:0] head;
        pick = $urandom_range(99);
        if (pick < 55)
            head = {own_addr, 1'b0};
        else if (pick < 70)
            head = {own_addr, 1'b1};
        else if (pick < 80)
            head = {own_addr ^ (7'd1 << $urandom_range(ADDR_W - 1)), 1'b0};
        else
            head = 8'($urandom_range(255));
        bus_start();
        put_byte(head);
        repeat (n_data)
        begin
            // after a mismatch a data byte is checked as an address again
            if ($urandom_range(99) < 20)
                put_byte({own_addr, 1'b0});
            else
                put_byte(8'($urandom_range(255)));
        end
        if ($urandom_range(99) < 70)
            bus_stop();
        else
            repeat ($urandom_range(7, 1))
                put_bit(1'($urandom_range(1)));
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned third;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Disabled: all outputs zero, levels only recorded
        push_sample(1'b0, 1'b0);
        push_sample(1'b1, 1'b0);
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b1);
        write_reg(CFG_ADDRESS, 7'h7f);
        write_reg(CFG_ENABLE, 7'h7f);

        // Start together with a rising clock, then stop
        push_sample(1'b1, 1'b0);
        push_sample(1'b0, 1'b1);
        push_sample(1'b0, 1'b0);
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b1);
        // bare start then stop with the clock held high
        push_sample(1'b0, 1'b1);
        push_sample(1'b1, 1'b1);
        push_sample(1'b1, 1'b0);

        // Random traffic in three idling phases
        third = samples_sent + RANDOM_SAMPLES / 3;
        while (samples_sent < third + 2 * (RANDOM_SAMPLES / 3))
        begin
            if (samples_sent >= third + RANDOM_SAMPLES / 3)
            begin
                idle_in  = 0;
                idle_out = 0;
            end
            else if (samples_sent >= third)
            begin
                if (idle_in != 78)
                    write_reg(CFG_ADDRESS, 7'h00);
                idle_in  = 78;
                idle_out = 38;
            end
            pick = $urandom_range(99);
            if (pick < 70)
                run_write($urandom_range(2));
            else if (pick < 85)
                repeat ($urandom_range(10, 1))
                    push_sample(1'($urandom_range(1)), 1'($urandom_range(1)));
            else if (pick < 92)
            begin
                if ($urandom_range(99) < 25)
                    write_reg(CFG_ADDRESS, $urandom_range(1) ? 7'h7f : 7'h00);
                else
                    write_reg(CFG_ADDRESS, 7'($urandom_range(127)));
            end
            else
                toggle_enable();
        end

        // One clean addressed write at full rate, data bytes back to back
        idle_in  = 0;
        idle_out = 0;
        hold_max = 1;
        write_reg(CFG_ENABLE, 7'h01);
        write_reg(CFG_ADDRESS, 7'($urandom_range(127)));
        bus_start();
        put_byte({own_addr, 1'b0});
        repeat (LONG_BYTES)
            put_byte(8'($urandom_range(255)));
        bus_stop();

        // Drain and decide
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* i2c_write_target_receiver_unit.f */
+incdir+design
design/i2c_wtr_pkg.sv
design/i2c_wtr_core.sv
design/i2c_wtr_out.sv
design/i2c_write_target_receiver_unit.sv
tb/sv/i2c_wtr_bus_checker.sv
tb/sv/tb_i2c_write_target_receiver_unit.sv
